[hdl/bpc_pkg.sv]
// ---------------------------------------------------------------------------
// bpc_pkg: shared types, constants and helpers
// Calibration set, register indexes, divider tag and integer helpers for the
// pressure and temperature compensation pipeline.
// ---------------------------------------------------------------------------
package bpc_pkg;

    // divider word width; one quotient bit per pipeline step
    localparam int DIV_W = 32;

    // compensation constants
    localparam logic signed [31:0] C_B6_OFS    = 32'sd4000;
    localparam logic signed [31:0] C_T_RND     = 32'sd8;
    localparam logic signed [31:0] C_B4_OFS    = 32'sd32768;
    localparam logic [15:0]        C_P_SCALE   = 16'd50000;
    localparam logic signed [15:0] C_P_X1_MUL  = 16'sd3038;
    localparam logic signed [15:0] C_P_X2_MUL  = -16'sd7357;
    localparam logic signed [31:0] C_P_OFS     = 32'sd3791;
    localparam logic signed [31:0] C_T_MAX     = 32'sd32767;
    localparam logic signed [31:0] C_T_MIN     = -32'sd32768;
    localparam logic signed [31:0] C_P_MAX     = 32'sd131071;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_AC1     = 3'd0,
        CFG_AC2     = 3'd1,
        CFG_AC3     = 3'd2,
        CFG_AC4     = 3'd3,
        CFG_AC5_AC6 = 3'd4,
        CFG_B1_B2   = 3'd5,
        CFG_MC_MD   = 3'd6,
        CFG_OSS     = 3'd7
    } t_cfg_idx;

    // calibration set
    typedef struct packed {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic [1:0]         oss;
    } t_cal;

    // sideband that rides along the divider
    typedef struct packed {
        logic [31:0] a;     // carried operand
        logic [18:0] up;    // raw pressure
        logic [15:0] t;     // temperature result
        logic        sel;   // negate / double select
        logic        flt;   // zero divisor seen
    } t_div_tag;

    // signed divide by 2^k, truncating toward zero
    function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] a,
                                                   input int unsigned k);
        logic signed [31:0] bias;
        bias = a[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
        return (a + bias) >>> k;
    endfunction

    // magnitude of a two's complement word
    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

[hdl/bpc_udiv.sv]
// ---------------------------------------------------------------------------
// bpc_udiv: pipelined unsigned divider
// Restoring division, one quotient bit per stage, a sideband tag travels
// with each request.
// ---------------------------------------------------------------------------
module bpc_udiv (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [31:0]        i_num,
    input  logic [31:0]        i_den,
    input  bpc_pkg::t_div_tag  i_tag,
    output logic               o_valid,
    output logic [31:0]        o_quo,
    output bpc_pkg::t_div_tag  o_tag
);
    import bpc_pkg::*;

    logic        r_v   [1:DIV_W];
    logic [31:0] r_rem [1:DIV_W];
    logic [31:0] r_nq  [1:DIV_W];
    logic [31:0] r_den [1:DIV_W];
    t_div_tag    r_tag [1:DIV_W];

    genvar k;
    generate
        for (k = 1; k <= DIV_W; k++) begin : g_step
            logic        v_in;
            logic [31:0] rem_in;
            logic [31:0] nq_in;
            logic [31:0] den_in;
            t_div_tag    tag_in;
            logic [32:0] sh;
            logic [32:0] diff;
            logic [31:0] n_rem;
            logic [31:0] n_nq;

            // stage source
            if (k == 1) begin : g_first
                assign v_in   = i_valid;
                assign rem_in = '0;
                assign nq_in  = i_num;
                assign den_in = i_den;
                assign tag_in = i_tag;
            end else begin : g_next
                assign v_in   = r_v[k-1];
                assign rem_in = r_rem[k-1];
                assign nq_in  = r_nq[k-1];
                assign den_in = r_den[k-1];
                assign tag_in = r_tag[k-1];
            end

            // shift in next numerator bit, trial subtract
            always_comb begin
                sh   = {rem_in, nq_in[DIV_W-1]};
                diff = sh - {1'b0, den_in};
                if (!diff[DIV_W]) begin
                    n_rem = diff[DIV_W-1:0];
                    n_nq  = {nq_in[DIV_W-2:0], 1'b1};
                end else begin
                    n_rem = sh[DIV_W-1:0];
                    n_nq  = {nq_in[DIV_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_nq[k]  <= n_nq;
                    r_den[k] <= den_in;
                    r_tag[k] <= tag_in;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[DIV_W];
    assign o_quo   = r_nq[DIV_W];
    assign o_tag   = r_tag[DIV_W];

endmodule

[hdl/bpc_temp.sv]
// ---------------------------------------------------------------------------
// bpc_temp: temperature section
// Computes B5 from the raw temperature word, including the signed division
// by X1 + MD, and flags a zero divisor.
// ---------------------------------------------------------------------------
module bpc_temp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [15:0]        i_raw_temperature,
    input  logic [18:0]        i_raw_pressure,
    input  bpc_pkg::t_cal      i_cal,
    output logic               o_valid,
    output logic signed [31:0] o_b5,
    output logic [18:0]        o_up,
    output logic               o_fault
);
    import bpc_pkg::*;

    logic signed [16:0] s_dt;
    logic signed [33:0] s_prod;
    logic signed [31:0] s_x1;
    logic signed [31:0] s_den;
    logic [31:0]        s_num;
    t_div_tag           s_tag;
    logic               s_dv;
    logic [31:0]        s_q;
    t_div_tag           s_qtag;
    logic signed [31:0] s_x2;

    logic               r_t1_v;
    logic signed [31:0] r_t1_prod;
    logic [18:0]        r_t1_up;
    logic               r_t2_v;
    logic signed [31:0] r_t2_x1;
    logic signed [31:0] r_t2_den;
    logic [18:0]        r_t2_up;
    logic               r_t4_v;
    logic signed [31:0] r_t4_b5;
    logic [18:0]        r_t4_up;
    logic               r_t4_flt;

    // stage 1: (UT - AC6) * AC5, low word
    always_comb begin
        s_dt   = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, i_cal.ac6});
        s_prod = s_dt * $signed({1'b0, i_cal.ac5});
    end

    // stage 2: X1 and divisor
    always_comb begin
        s_x1  = sdiv_p2(r_t1_prod, 15);
        s_den = s_x1 + {{16{i_cal.md[15]}}, i_cal.md};
    end

    // divider request: |MC * 2048| / |den|
    always_comb begin
        s_num     = {{5{i_cal.mc[15]}}, i_cal.mc, 11'b0};
        s_tag.a   = r_t2_x1;
        s_tag.up  = r_t2_up;
        s_tag.t   = '0;
        s_tag.sel = s_num[31] ^ r_t2_den[31];
        s_tag.flt = (r_t2_den == 32'sd0);
    end

    bpc_udiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_t2_v),
        .i_num   (mag32(s_num)),
        .i_den   (mag32(r_t2_den)),
        .i_tag   (s_tag),
        .o_valid (s_dv),
        .o_quo   (s_q),
        .o_tag   (s_qtag)
    );

    // restore sign of X2
    assign s_x2 = s_qtag.sel ? $signed(~s_q + 32'd1) : $signed(s_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
            r_t4_v <= 1'b0;
        end else if (i_en) begin
            r_t1_v <= i_valid;
            r_t2_v <= r_t1_v;
            r_t4_v <= s_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1_prod <= s_prod[31:0];
            r_t1_up   <= i_raw_pressure;
            r_t2_x1   <= s_x1;
            r_t2_den  <= s_den;
            r_t2_up   <= r_t1_up;
            r_t4_b5   <= $signed(s_qtag.a) + s_x2;
            r_t4_up   <= s_qtag.up;
            r_t4_flt  <= s_qtag.flt;
        end
    end

    assign o_valid = r_t4_v;
    assign o_b5    = r_t4_b5;
    assign o_up    = r_t4_up;
    assign o_fault = r_t4_flt;

endmodule

[hdl/bpc_press.sv]
// ---------------------------------------------------------------------------
// bpc_press: pressure section
// Temperature result, B3/B4/B7, the unsigned pressure division and the final
// polynomial correction with saturation.
// ---------------------------------------------------------------------------
module bpc_press (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_b5,
    input  logic [18:0]        i_up,
    input  logic               i_fault,
    input  bpc_pkg::t_cal      i_cal,
    output logic               o_valid,
    output logic signed [15:0] o_temperature_decidegrees,
    output logic [16:0]        o_pressure_pa,
    output logic               o_fault
);
    import bpc_pkg::*;

    typedef struct packed {
        logic [15:0] t;
        logic [18:0] up;
        logic        flt;
    } t_side;

    // stage 1 comb
    logic signed [31:0] s_tq;
    logic [15:0]        s_t;
    // stage 2 comb
    logic signed [63:0] s_sq;
    logic signed [47:0] s_ma2;
    logic signed [47:0] s_ma3;
    // stage 4 comb
    logic signed [47:0] s_mb2;
    logic signed [47:0] s_mb1;
    // stage 6 comb
    logic [31:0]        s_b3s;
    // stage 7 comb
    logic [47:0]        s_mb4;
    // stage 8 comb
    logic [15:0]        s_scale;
    logic [47:0]        s_b7;
    // divider
    logic [31:0]        s_num;
    t_div_tag           s_tag;
    logic               s_dv;
    logic [31:0]        s_q;
    t_div_tag           s_qtag;
    // after divider
    logic signed [31:0] s_p;
    logic signed [47:0] s_my;
    logic signed [63:0] s_mx;
    logic signed [47:0] s_m2;
    logic signed [31:0] s_sum;
    logic signed [31:0] s_pf;
    logic [16:0]        s_pc;

    logic r_v [1:8];
    t_side r_sd [1:8];

    logic signed [31:0] r_p1_b6;
    logic signed [31:0] r_p2_sqp;
    logic signed [31:0] r_p2_ma2;
    logic signed [31:0] r_p2_ma3;
    logic signed [31:0] r_p3_sq;
    logic signed [31:0] r_p3_x2a;
    logic signed [31:0] r_p3_x1c;
    logic signed [31:0] r_p4_mb2;
    logic signed [31:0] r_p4_mb1;
    logic signed [31:0] r_p4_x2a;
    logic signed [31:0] r_p4_x1c;
    logic signed [31:0] r_p5_x3;
    logic signed [31:0] r_p5_x2b;
    logic signed [31:0] r_p5_x1c;
    logic signed [31:0] r_p6_b3;
    logic signed [31:0] r_p6_x3b;
    logic [31:0]        r_p7_mb4;
    logic [31:0]        r_p7_diff;
    logic [31:0]        r_p8_b4;
    logic [31:0]        r_p8_b7;

    logic               r_p9_v;
    logic [15:0]        r_p9_t;
    logic               r_p9_flt;
    logic signed [31:0] r_p9_p;
    logic signed [31:0] r_p9_q8;
    logic signed [31:0] r_p9_my;
    logic               r_p10_v;
    logic [15:0]        r_p10_t;
    logic               r_p10_flt;
    logic signed [31:0] r_p10_p;
    logic signed [31:0] r_p10_mx;
    logic signed [31:0] r_p10_x2;
    logic               r_p11_v;
    logic [15:0]        r_p11_t;
    logic               r_p11_flt;
    logic signed [31:0] r_p11_p;
    logic signed [31:0] r_p11_m2;
    logic signed [31:0] r_p11_x2;
    logic               r_out_v;
    logic [15:0]        r_out_t;
    logic [16:0]        r_out_p;
    logic               r_out_flt;

    // stage 1: temperature rounding and saturation, B6
    always_comb begin
        s_tq = sdiv_p2(i_b5 + C_T_RND, 4);
        if (s_tq > C_T_MAX) begin
            s_t = C_T_MAX[15:0];
        end else if (s_tq < C_T_MIN) begin
            s_t = C_T_MIN[15:0];
        end else begin
            s_t = s_tq[15:0];
        end
    end

    // stage 2: B6^2, AC2*B6, AC3*B6
    always_comb begin
        s_sq  = r_p1_b6 * r_p1_b6;
        s_ma2 = i_cal.ac2 * r_p1_b6;
        s_ma3 = i_cal.ac3 * r_p1_b6;
    end

    // stage 4: B2*sq, B1*sq
    always_comb begin
        s_mb2 = i_cal.b2 * r_p3_sq;
        s_mb1 = i_cal.b1 * r_p3_sq;
    end

    // stage 6: B3 before rounding
    assign s_b3s = 32'((i_cal.ac1 <<< 2) + r_p5_x3) << i_cal.oss;

    // stage 7: AC4 * (X3 + 32768)
    assign s_mb4 = i_cal.ac4 * $unsigned(r_p6_x3b + C_B4_OFS);

    // stage 8: B7
    always_comb begin
        s_scale = C_P_SCALE >> i_cal.oss;
        s_b7    = r_p7_diff * s_scale;
    end

    // divider request: B7 doubled before or after the division
    always_comb begin
        s_num     = r_p8_b7[31] ? r_p8_b7 : {r_p8_b7[30:0], 1'b0};
        s_tag.a   = '0;
        s_tag.up  = '0;
        s_tag.t   = r_sd[8].t;
        s_tag.sel = r_p8_b7[31];
        s_tag.flt = r_sd[8].flt | (r_p8_b4 == 32'd0);
    end

    bpc_udiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v[8]),
        .i_num   (s_num),
        .i_den   (r_p8_b4),
        .i_tag   (s_tag),
        .o_valid (s_dv),
        .o_quo   (s_q),
        .o_tag   (s_qtag)
    );

    // post-divide terms
    always_comb begin
        s_p  = s_qtag.sel ? $signed({s_q[30:0], 1'b0}) : $signed(s_q);
        s_my = C_P_X2_MUL * s_p;
        s_mx = r_p9_q8 * r_p9_q8;
        s_m2 = C_P_X1_MUL * r_p10_mx;
    end

    // final correction and clamp
    always_comb begin
        s_sum = sdiv_p2(sdiv_p2(r_p11_m2, 16) + r_p11_x2 + C_P_OFS, 4);
        s_pf  = r_p11_p + s_sum;
        if (s_pf < 32'sd0) begin
            s_pc = '0;
        end else if (s_pf > C_P_MAX) begin
            s_pc = C_P_MAX[16:0];
        end else begin
            s_pc = s_pf[16:0];
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= 8; i++) begin
                r_v[i] <= 1'b0;
            end
            r_p9_v  <= 1'b0;
            r_p10_v <= 1'b0;
            r_p11_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_v[1] <= i_valid;
            for (int i = 2; i <= 8; i++) begin
                r_v[i] <= r_v[i-1];
            end
            r_p9_v  <= s_dv;
            r_p10_v <= r_p9_v;
            r_p11_v <= r_p10_v;
            r_out_v <= r_p11_v;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sd[1].t   <= s_t;
            r_sd[1].up  <= i_up;
            r_sd[1].flt <= i_fault;
            for (int i = 2; i <= 8; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
            r_p1_b6   <= i_b5 - C_B6_OFS;
            r_p2_sqp  <= s_sq[31:0];
            r_p2_ma2  <= s_ma2[31:0];
            r_p2_ma3  <= s_ma3[31:0];
            r_p3_sq   <= sdiv_p2(r_p2_sqp, 12);
            r_p3_x2a  <= sdiv_p2(r_p2_ma2, 11);
            r_p3_x1c  <= r_p2_ma3 >>> 13;
            r_p4_mb2  <= s_mb2[31:0];
            r_p4_mb1  <= s_mb1[31:0];
            r_p4_x2a  <= r_p3_x2a;
            r_p4_x1c  <= r_p3_x1c;
            r_p5_x3   <= sdiv_p2(r_p4_mb2, 11) + r_p4_x2a;
            r_p5_x2b  <= sdiv_p2(r_p4_mb1, 16);
            r_p5_x1c  <= r_p4_x1c;
            r_p6_b3   <= sdiv_p2($signed(s_b3s) + 32'sd2, 2);
            r_p6_x3b  <= sdiv_p2(r_p5_x1c + r_p5_x2b + 32'sd2, 2);
            r_p7_mb4  <= s_mb4[31:0];
            r_p7_diff <= {13'b0, r_sd[6].up} - $unsigned(r_p6_b3);
            r_p8_b4   <= r_p7_mb4 >> 15;
            r_p8_b7   <= s_b7[31:0];
            r_p9_t    <= s_qtag.t;
            r_p9_flt  <= s_qtag.flt;
            r_p9_p    <= s_p;
            r_p9_q8   <= sdiv_p2(s_p, 8);
            r_p9_my   <= s_my[31:0];
            r_p10_t   <= r_p9_t;
            r_p10_flt <= r_p9_flt;
            r_p10_p   <= r_p9_p;
            r_p10_mx  <= s_mx[31:0];
            r_p10_x2  <= sdiv_p2(r_p9_my, 16);
            r_p11_t   <= r_p10_t;
            r_p11_flt <= r_p10_flt;
            r_p11_p   <= r_p10_p;
            r_p11_m2  <= s_m2[31:0];
            r_p11_x2  <= r_p10_x2;
            r_out_t   <= r_p11_flt ? 16'd0 : r_p11_t;
            r_out_p   <= r_p11_flt ? 17'd0 : s_pc;
            r_out_flt <= r_p11_flt;
        end
    end

    assign o_valid                   = r_out_v;
    assign o_temperature_decidegrees = $signed(r_out_t);
    assign o_pressure_pa             = r_out_p;
    assign o_fault                   = r_out_flt;

endmodule

[hdl/baro_pressure_temp_compensation.sv]
// Fully pipelined barometric compensation: one raw temperature / pressure
// request enters per cycle while no finished result is stalled, and passes
// the temperature section and then the pressure section, each of which holds
// one of the two 32-stage bit-per-stage dividers. The whole pipeline holds
// while a finished result is stalled; bubbles pass freely. A zero divisor
// returns fault with both readings zero. Calibration writes are taken at any
// time, ready is always high, and must be done while the pipeline is empty.
// ---------------------------------------------------------------------------
// baro_pressure_temp_compensation: top level
// Calibration registers, pipeline enable and the two compensation sections.
// ---------------------------------------------------------------------------
module baro_pressure_temp_compensation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_raw_temperature,
    input  logic [18:0]        i_raw_pressure,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_temperature_decidegrees,
    output logic [16:0]        o_pressure_pa,
    output logic               o_fault,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import bpc_pkg::*;

    t_cal               r_cal;
    logic               s_en;
    logic               s_tv;
    logic signed [31:0] s_b5;
    logic [18:0]        s_up;
    logic               s_tflt;

    // pipeline advances unless the output is held
    assign s_en        = !(o_valid && i_stall);
    assign o_stall     = !s_en;
    assign o_cfg_ready = 1'b1;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // all coefficients zero, oversampling (lowest field) three
            r_cal <= {{($bits(t_cal) - 2){1'b0}}, 2'd3};
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_AC1:     r_cal.ac1 <= $signed(i_cfg_data[15:0]);
                CFG_AC2:     r_cal.ac2 <= $signed(i_cfg_data[15:0]);
                CFG_AC3:     r_cal.ac3 <= $signed(i_cfg_data[15:0]);
                CFG_AC4:     r_cal.ac4 <= i_cfg_data[15:0];
                CFG_AC5_AC6: begin
                    r_cal.ac5 <= i_cfg_data[31:16];
                    r_cal.ac6 <= i_cfg_data[15:0];
                end
                CFG_B1_B2: begin
                    r_cal.b1 <= $signed(i_cfg_data[31:16]);
                    r_cal.b2 <= $signed(i_cfg_data[15:0]);
                end
                CFG_MC_MD: begin
                    r_cal.mc <= $signed(i_cfg_data[31:16]);
                    r_cal.md <= $signed(i_cfg_data[15:0]);
                end
                CFG_OSS:     r_cal.oss <= i_cfg_data[1:0];
                default:     r_cal <= r_cal;
            endcase
        end
    end

    bpc_temp u_temp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (s_en),
        .i_valid           (i_valid),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .i_cal             (r_cal),
        .o_valid           (s_tv),
        .o_b5              (s_b5),
        .o_up              (s_up),
        .o_fault           (s_tflt)
    );

    bpc_press u_press (
        .i_clk                     (i_clk),
        .i_rst_n                   (i_rst_n),
        .i_en                      (s_en),
        .i_valid                   (s_tv),
        .i_b5                      (s_b5),
        .i_up                      (s_up),
        .i_fault                   (s_tflt),
        .i_cal                     (r_cal),
        .o_valid                   (o_valid),
        .o_temperature_decidegrees (o_temperature_decidegrees),
        .o_pressure_pa             (o_pressure_pa),
        .o_fault                   (o_fault)
    );

    // a faulted result carries zero readings
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fault) |-> (o_temperature_decidegrees == 16'sd0 &&
                                  o_pressure_pa == 17'd0))
        else $error("fault result with nonzero readings");

    // input stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_pressure_pa) &&
                                  $stable(o_temperature_decidegrees) && $stable(o_fault)))
        else $error("held result changed");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: barometric compensation pipeline testbench
// Writes calibration sets, streams raw temperature / pressure requests with
// random idling on both sides, and checks every result against a behavioral
// model of the integer compensation kept in this file or a typed-in table value.
// ---------------------------------------------------------------------------
module tb;
    import bpc_pkg::*;

    localparam int LATENCY   = 79;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 850;

    typedef struct {
        logic signed [15:0] temp;
        logic [16:0]        pres;
        logic               flt;
        bit                 fixed;  // expected value typed into the table
    } t_reading;

    typedef struct {
        logic [15:0] ut;
        logic [18:0] up;
        bit          fixed;
        logic signed [15:0] temp;
        logic [16:0] pres;
        logic        flt;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [15:0]        i_raw_temperature = '0;
    logic [18:0]        i_raw_pressure = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_temperature_decidegrees;
    logic [16:0]        o_pressure_pa;
    logic               o_fault;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    // calibration copy
    int          m_ac1, m_ac2, m_ac3, m_b1, m_b2, m_mc, m_md;
    int unsigned m_ac4, m_ac5, m_ac6, m_oss;

    t_reading    pending_readings[$];
    int          n_errors = 0;
    int          n_checked = 0;
    int          n_faults = 0;
    int          idle_cycles = 0;
    bit          rx_idle_en = 1'b0;
    bit          rx_hold = 1'b0;
    bit          random_phase = 1'b0;

    always #5 i_clk = ~i_clk;

    baro_pressure_temp_compensation dut (.*);

    // signed division truncating toward zero in 32-bit terms
    function automatic int tdiv(int a, int b);
        return a / b;
    endfunction

    function automatic int sx16(logic [15:0] v);
        return int'(signed'(v));
    endfunction

    function automatic void apply_cal(t_cfg_idx idx, logic [31:0] v);
        case (idx)
            CFG_AC1:     m_ac1 = sx16(v[15:0]);
            CFG_AC2:     m_ac2 = sx16(v[15:0]);
            CFG_AC3:     m_ac3 = sx16(v[15:0]);
            CFG_AC4:     m_ac4 = {16'd0, v[15:0]};
            CFG_AC5_AC6: begin m_ac5 = {16'd0, v[31:16]}; m_ac6 = {16'd0, v[15:0]}; end
            CFG_B1_B2:   begin m_b1 = sx16(v[31:16]); m_b2 = sx16(v[15:0]); end
            CFG_MC_MD:   begin m_mc = sx16(v[31:16]); m_md = sx16(v[15:0]); end
            CFG_OSS:     m_oss = {30'd0, v[1:0]};
            default:     ;
        endcase
    endfunction

    // integer compensation of one sample pair
    function automatic t_reading compensate(logic [15:0] ut_raw, logic [18:0] up_raw);
        t_reading r;
        int x1, x2, x3, b3, b5, b6, den, t, p, sq;
        int unsigned b4, b7, pu, uv;
        r.temp = '0; r.pres = '0; r.flt = 1'b1; r.fixed = 1'b0;
        x1 = tdiv((int'(ut_raw) - int'(m_ac6)) * int'(m_ac5), 32768);
        den = x1 + m_md;
        if (den == 0) return r;
        x2 = tdiv(m_mc * 2048, den);
        b5 = x1 + x2;
        t = tdiv(b5 + 8, 16);
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;

        b6 = b5 - 4000;
        sq = tdiv(b6 * b6, 4096);
        x1 = tdiv(m_b2 * sq, 2048);
        x2 = tdiv(m_ac2 * b6, 2048);
        x3 = x1 + x2;
        uv = int'(m_ac1 * 4 + x3);
        b3 = int'(uv << m_oss);
        b3 = tdiv(b3 + 2, 4);

        x1 = (m_ac3 * b6) >>> 13;
        x2 = tdiv(m_b1 * sq, 65536);
        x3 = tdiv(x1 + x2 + 2, 4);
        b4 = (m_ac4 * int'(x3 + 32768)) / 32'd32768;
        if (b4 == 0) return r;
        b7 = (int'(up_raw) - b3) * (32'd50000 >> m_oss);
        if (b7 < 32'h8000_0000) pu = (b7 * 2) / b4;
        else pu = (b7 / b4) * 2;
        p = int'(pu);

        x1 = tdiv(p, 256) * tdiv(p, 256);
        x1 = tdiv(x1 * 3038, 65536);
        x2 = tdiv(-7357 * p, 65536);
        p = p + tdiv(x1 + x2 + 3791, 16);
        if (p < 0) p = 0;
        if (p > 131071) p = 131071;
        r.temp = t[15:0];
        r.pres = p[16:0];
        r.flt = 1'b0;
        return r;
    endfunction

    // request side: drive one pair, hold until taken; valid stays up for the next
    task automatic send_pair(logic [15:0] ut, logic [18:0] up, bit idle, t_reading exp_r);
        while (idle && ($urandom_range(99) < 27)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_raw_temperature <= ut;
        i_raw_pressure <= up;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_readings.push_back(exp_r);
        @(negedge i_clk);
    endtask

    task automatic send_model(logic [15:0] ut, logic [18:0] up, bit idle);
        send_pair(ut, up, idle, compensate(ut, up));
    endtask

    task automatic write_cal(t_cfg_idx idx, logic [31:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_cal(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // stop sending, wait for the pipeline to drain, then let it settle
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    // typical datasheet calibration set
    task automatic load_typical();
        write_cal(CFG_AC1, 32'd408);
        write_cal(CFG_AC2, -32'sd72);
        write_cal(CFG_AC3, -32'sd14383);
        write_cal(CFG_AC4, 32'd32741);
        write_cal(CFG_AC5_AC6, {16'd32757, 16'd23153});
        write_cal(CFG_B1_B2, {16'd6190, 16'd4});
        write_cal(CFG_MC_MD, {-16'sd8711, 16'd2868});
    endtask

    task automatic load_random();
        t_cfg_idx idx;
        for (int k = 0; k <= 7; k++) begin
            idx = t_cfg_idx'(k);
            write_cal(idx, $urandom());
        end
    endtask

    // result side: stall at random, check in order
    always @(negedge i_clk) begin
        if (rx_hold) i_stall <= 1'b1;
        else if (rx_idle_en) i_stall <= ($urandom_range(99) < 27);
        else i_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_reading e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected result temp=%0d pres=%0d fault=%0b",
                    $time, o_temperature_decidegrees, o_pressure_pa, o_fault);
                n_errors++;
            end else begin
                e = pending_readings.pop_front();
                n_checked++;
                if (e.flt) n_faults++;
                if (o_temperature_decidegrees !== e.temp) begin
                    $display("%0t: temperature expected %0d actual %0d", $time, e.temp,
                        o_temperature_decidegrees);
                    n_errors++;
                end
                if (o_pressure_pa !== e.pres) begin
                    $display("%0t: pressure expected %0d actual %0d", $time, e.pres,
                        o_pressure_pa);
                    n_errors++;
                end
                if (o_fault !== e.flt) begin
                    $display("%0t: fault expected %0b actual %0b", $time, e.flt, o_fault);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // long receiver hold-off during the random part
    initial begin
        wait (random_phase);
        repeat (300) @(negedge i_clk);
        rx_hold = 1'b1;
        repeat (400) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    t_row rows[$];
    t_reading fx;

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all coefficients zero after reset: md zero makes the divisor zero
        rows = '{
            '{16'd0,     19'd0,      1'b1, 16'sd0, 17'd0, 1'b1},
            '{16'hFFFF,  19'h7FFFF,  1'b1, 16'sd0, 17'd0, 1'b1}
        };
        foreach (rows[k]) begin
            fx.temp = rows[k].temp; fx.pres = rows[k].pres;
            fx.flt = rows[k].flt; fx.fixed = 1'b1;
            send_pair(rows[k].ut, rows[k].up, 1'b0, fx);
        end
        drain();

        // typical coefficients, all oversampling settings, field extremes
        load_typical();
        rows = '{
            '{16'd27898, 19'd23843,  1'b0, 16'sd0, 17'd0, 1'b0},
            '{16'd0,     19'd0,      1'b0, 16'sd0, 17'd0, 1'b0},
            '{16'hFFFF,  19'h7FFFF,  1'b0, 16'sd0, 17'd0, 1'b0},
            '{16'h5555,  19'h2AAAA,  1'b0, 16'sd0, 17'd0, 1'b0},
            '{16'hAAAA,  19'h55555,  1'b0, 16'sd0, 17'd0, 1'b0},
            '{16'd23153, 19'd40000,  1'b0, 16'sd0, 17'd0, 1'b0}
        };
        for (int o = 0; o <= 3; o++) begin
            write_cal(CFG_OSS, o);
            foreach (rows[k]) send_model(rows[k].ut, rows[k].up, 1'b0);
            drain();
        end
        // ac4 zero: sensitivity zero gives fault
        write_cal(CFG_AC4, 32'd0);
        send_model(16'd27898, 19'd23843, 1'b0);
        drain();
        // coefficient extremes
        write_cal(CFG_AC1, 32'h8000);
        write_cal(CFG_AC2, 32'h7FFF);
        write_cal(CFG_AC3, 32'h8000);
        write_cal(CFG_AC4, 32'hFFFF);
        write_cal(CFG_AC5_AC6, 32'hFFFF_FFFF);
        write_cal(CFG_B1_B2, 32'h8000_7FFF);
        write_cal(CFG_MC_MD, 32'h7FFF_8000);
        send_model(16'd0, 19'h7FFFF, 1'b0);
        send_model(16'hFFFF, 19'd0, 1'b0);
        drain();

        // random part: several calibration sets, mostly realistic
        random_phase = 1'b1;
        rx_idle_en = 1'b1;
        for (int s = 0; s < 6; s++) begin
            if (s == 2 || s == 4) load_random();
            else begin
                load_typical();
                write_cal(CFG_OSS, $urandom_range(3));
            end
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                if (s == 1 && k < 60) begin
                    // no idling on either side for a stretch
                    rx_idle_en = 1'b0;
                    send_model(16'($urandom()), 19'($urandom()), 1'b0);
                end else begin
                    rx_idle_en = 1'b1;
                    if ($urandom_range(3) != 0)
                        send_model(16'($urandom_range(32000, 20000)),
                            19'($urandom_range(60000, 10000) << $urandom_range(3)), 1'b1);
                    else send_model(16'($urandom()), 19'($urandom()), 1'b1);
                end
            end
            // sender pauses until every result is back
            drain();
        end

        rx_idle_en = 1'b0;
        drain();
        $display("Checked %0d results (%0d with fault) over directed and random sets.",
            n_checked, n_faults);
        if (n_errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
